@@ design/difference_alpha_extractor_macros.svh @@
// ---------------------------------------------------------------------------
// difference_alpha_extractor_macros
// Assertion helpers shared by the difference alpha extractor RTL.
// ---------------------------------------------------------------------------
`ifndef DIFFERENCE_ALPHA_EXTRACTOR_MACROS_SVH
`define DIFFERENCE_ALPHA_EXTRACTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DAE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DAE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dae_pkg.sv @@
// ---------------------------------------------------------------------------
// dae_pkg
// Shared types, constants and helpers of the difference alpha extractor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dae_pkg;

    localparam int unsigned CH_W        = 8;
    localparam int unsigned SIZE_W      = 13;
    localparam int unsigned BOX_W       = 12;
    localparam int unsigned IN_W        = 6 * CH_W;
    localparam int unsigned OUT_W       = 5 * CH_W + 4 * BOX_W;
    localparam int unsigned DEF_MAX_DIM = 4096;

    localparam logic [SIZE_W-1:0] DEF_FRAME_WIDTH  = 13'd1920;
    localparam logic [SIZE_W-1:0] DEF_FRAME_HEIGHT = 13'd1080;

    typedef enum logic [1:0] {
        GRAY_AVG   = 2'd0,
        GRAY_LUM   = 2'd1,
        GRAY_LIGHT = 2'd2
    } gray_mode_t;

    typedef enum logic [1:0] {
        CFG_GRAY_MODE    = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic restart;
        logic advance;
    } dae_ctrl_t;

    typedef struct packed {
        logic             frame_done;
        logic             crop_apply;
        logic [BOX_W-1:0] box_left;
        logic [BOX_W-1:0] box_right;
        logic [BOX_W-1:0] box_top;
        logic [BOX_W-1:0] box_bottom;
    } dae_status_t;

    // Last valid coordinate for a programmed size: 0 acts as 1, clamp to max_dim.
    function automatic logic [16:0] eff_last(input logic [SIZE_W-1:0] size,
                                             input int unsigned max_dim);
        if (size == '0) begin
            return '0;
        end else if (32'(size) > max_dim) begin
            return 17'(max_dim - 1);
        end else begin
            return 17'(size - 13'd1);
        end
    endfunction

endpackage

@@ design/dae_gray.sv @@
// ---------------------------------------------------------------------------
// dae_gray
// RGB to gray conversion: average, luminosity or lightness.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dae_gray (
    input  logic [1:0]              mode,
    input  logic [dae_pkg::CH_W-1:0] red,
    input  logic [dae_pkg::CH_W-1:0] green,
    input  logic [dae_pkg::CH_W-1:0] blue,
    output logic [dae_pkg::CH_W-1:0] gray
);
    import dae_pkg::*;

    logic [9:0]  sum3;
    logic [10:0] avg_num;
    logic [24:0] avg_prod;
    logic [14:0] lum_num;
    logic [27:0] lum_prod;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [8:0]  light_sum;

    always_comb begin
        // round((r+g+b)/3) = (2s+3)/6, divide by 6 via 10923/2^16
        sum3     = 10'(red) + 10'(green) + 10'(blue);
        avg_num  = {sum3, 1'b0} + 11'd3;
        avg_prod = 25'(avg_num) * 25'd10923;

        // 21r + 72g + 7b + 50 as shift-adds, divide by 100 via 5243/2^19
        lum_num  = (15'(red) << 4) + (15'(red) << 2) + 15'(red)
                 + (15'(green) << 6) + (15'(green) << 3)
                 + (15'(blue) << 3) - 15'(blue)
                 + 15'd50;
        lum_prod = 28'(lum_num) * 28'd5243;

        hi = red;
        lo = red;
        if (green > hi) hi = green;
        if (blue > hi)  hi = blue;
        if (green < lo) lo = green;
        if (blue < lo)  lo = blue;
        light_sum = 9'(hi) + 9'(lo) + 9'd1;

        case (mode)
            GRAY_AVG:   gray = avg_prod[23:16];
            GRAY_LIGHT: gray = light_sum[8:1];
            default:    gray = lum_prod[26:19];
        endcase
    end

endmodule

@@ design/dae_tracker.sv @@
// ---------------------------------------------------------------------------
// dae_tracker
// Raster position counters, bounding box and frame-end crop decision.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "difference_alpha_extractor_macros.svh"

module dae_tracker #(
    parameter int unsigned MAX_DIM = dae_pkg::DEF_MAX_DIM,
    parameter int unsigned CNT_W   = $clog2(MAX_DIM)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dae_pkg::dae_ctrl_t  ctrl,
    input  logic                diff_max,
    input  logic [CNT_W-1:0]    last_col,
    input  logic [CNT_W-1:0]    last_line,
    output dae_pkg::dae_status_t status
);
    import dae_pkg::*;

    localparam logic [CNT_W-1:0] RST_LAST_COL  = CNT_W'(eff_last(DEF_FRAME_WIDTH, MAX_DIM));
    localparam logic [CNT_W-1:0] RST_LAST_LINE = CNT_W'(eff_last(DEF_FRAME_HEIGHT, MAX_DIM));

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] line_reg, line_next;
    logic [CNT_W-1:0] left_reg, left_next, left_upd;
    logic [CNT_W-1:0] right_reg, right_next, right_upd;
    logic [CNT_W-1:0] top_reg, top_next, top_upd;
    logic [CNT_W-1:0] bottom_reg, bottom_next, bottom_upd;
    logic             hit;
    logic             col_end;
    logic             done;

    always_comb begin
        hit        = !diff_max;
        left_upd   = (hit && col_reg < left_reg)     ? col_reg  : left_reg;
        right_upd  = (hit && col_reg > right_reg)    ? col_reg  : right_reg;
        top_upd    = (hit && line_reg < top_reg)     ? line_reg : top_reg;
        bottom_upd = (hit && line_reg > bottom_reg)  ? line_reg : bottom_reg;

        col_end = (col_reg >= last_col);
        done    = col_end && (line_reg >= last_line);

        status.frame_done = done;
        status.crop_apply = done && (left_upd < right_upd) && (top_upd < bottom_upd)
                          && ((left_upd != '0) || (top_upd != '0)
                              || (right_upd < last_col) || (bottom_upd < last_line));
        status.box_left   = BOX_W'(left_upd);
        status.box_right  = BOX_W'(right_upd);
        status.box_top    = BOX_W'(top_upd);
        status.box_bottom = BOX_W'(bottom_upd);

        col_next    = col_reg;
        line_next   = line_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;

        if (ctrl.restart || (ctrl.advance && done)) begin
            col_next    = '0;
            line_next   = '0;
            left_next   = last_col;
            right_next  = '0;
            top_next    = last_line;
            bottom_next = '0;
        end else if (ctrl.advance) begin
            left_next   = left_upd;
            right_next  = right_upd;
            top_next    = top_upd;
            bottom_next = bottom_upd;
            if (col_end) begin
                col_next  = '0;
                line_next = line_reg + CNT_W'(1);
            end else begin
                col_next  = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            line_reg   <= '0;
            left_reg   <= RST_LAST_COL;
            right_reg  <= '0;
            top_reg    <= RST_LAST_LINE;
            bottom_reg <= '0;
        end else begin
            col_reg    <= col_next;
            line_reg   <= line_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
        end
    end

    `DAE_ASSERT_NEXT(a_frame_wrap, aclk, aresetn, ctrl.advance && done, (col_reg == '0) && (line_reg == '0), "counters did not wrap at frame end")
    `DAE_ASSERT_NOW(a_col_range, aclk, aresetn, !ctrl.restart, col_reg <= last_col, "column beyond line width")
    `DAE_ASSERT_NOW(a_line_range, aclk, aresetn, !ctrl.restart, line_reg <= last_line, "line beyond frame height")

endmodule

@@ design/difference_alpha_extractor.sv @@
// ---------------------------------------------------------------------------
// difference_alpha_extractor - gray difference, channel mean and alpha per pixel pair
// Path from input word accept to result word valid: input reg, then result reg.
// Throughput: one pixel pair per clock while m_tready holds; gray, diff and box update share one stage.
// Reset: aresetn low clears both stages, loads mode 1 and 1920x1080, restarts the frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "difference_alpha_extractor_macros.svh"

module difference_alpha_extractor #(
    parameter int unsigned MAX_DIM = dae_pkg::DEF_MAX_DIM
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    // Pixel pair stream.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [7:0] first_red, [15:8] first_green, [23:16] first_blue,
    // [31:24] second_red, [39:32] second_green, [47:40] second_blue
    input  logic [dae_pkg::IN_W-1:0]   s_tdata,

    // Result stream.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] gray_diff, [15:8] mean_red, [23:16] mean_green, [31:24] mean_blue,
    // [39:32] alpha_out, [51:40] box_left, [63:52] box_right,
    // [75:64] box_top, [87:76] box_bottom
    output logic [dae_pkg::OUT_W-1:0]  m_tdata,
    output logic                       m_tlast,   // frame_done
    output logic                       m_tuser,   // [0] crop_apply

    // Register write channel: 0 gray_mode, 1 frame_width, 2 frame_height.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [dae_pkg::SIZE_W-1:0] cfg_data
);
    import dae_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_DIM);

    // ---------------------------------------------------------------
    // Configuration registers. Ready whenever out of reset; size writes
    // restart the frame.
    // ---------------------------------------------------------------
    logic [1:0]        gray_mode_reg, gray_mode_next;
    logic [SIZE_W-1:0] frame_width_reg, frame_width_next;
    logic [SIZE_W-1:0] frame_height_reg, frame_height_next;
    logic              cfg_fire;
    logic              size_write;

    assign cfg_ready = aresetn;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb begin
        gray_mode_next    = gray_mode_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        size_write        = 1'b0;
        if (cfg_fire) begin
            case (cfg_index)
                CFG_GRAY_MODE: begin
                    gray_mode_next = cfg_data[1:0];
                end
                CFG_FRAME_WIDTH: begin
                    frame_width_next = cfg_data;
                    size_write       = 1'b1;
                end
                CFG_FRAME_HEIGHT: begin
                    frame_height_next = cfg_data;
                    size_write        = 1'b1;
                end
                default: begin
                    // unmapped index: dropped
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_mode_reg    <= GRAY_LUM;
            frame_width_reg  <= DEF_FRAME_WIDTH;
            frame_height_reg <= DEF_FRAME_HEIGHT;
        end else begin
            gray_mode_reg    <= gray_mode_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // Effective last coordinates; taken from the _next values so a restart
    // reloads the box from the size being written this cycle.
    logic [CNT_W-1:0] last_col;
    logic [CNT_W-1:0] last_line;

    assign last_col  = CNT_W'(eff_last(frame_width_next, MAX_DIM));
    assign last_line = CNT_W'(eff_last(frame_height_next, MAX_DIM));

    // ---------------------------------------------------------------
    // Two-register pipe: input register -> compute -> result register.
    // Input side keeps taking words while a result waits, as long as the
    // input register is empty or moves on this cycle. Not ready in reset.
    // ---------------------------------------------------------------
    logic [IN_W-1:0] pix_reg;
    logic            a_valid_reg, a_valid_next;
    logic            b_ready;
    logic            a_advance;
    logic            in_fire;

    assign b_ready   = !m_tvalid || m_tready;
    assign a_advance = a_valid_reg && b_ready;
    assign s_tready  = aresetn && (!a_valid_reg || b_ready);
    assign in_fire   = s_tvalid && s_tready;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (in_fire) begin
            a_valid_next = 1'b1;
        end else if (a_advance) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            pix_reg <= s_tdata;
        end
    end

    // ---------------------------------------------------------------
    // Per-pixel math on the input register.
    // ---------------------------------------------------------------
    logic [CH_W-1:0] gray_first;
    logic [CH_W-1:0] gray_second;
    logic [CH_W-1:0] diff;
    logic [CH_W-1:0] alpha;
    logic [CH_W:0]   sum_red, sum_green, sum_blue;

    dae_gray u_gray_first (
        .mode  (gray_mode_reg),
        .red   (pix_reg[7:0]),
        .green (pix_reg[15:8]),
        .blue  (pix_reg[23:16]),
        .gray  (gray_first)
    );

    dae_gray u_gray_second (
        .mode  (gray_mode_reg),
        .red   (pix_reg[31:24]),
        .green (pix_reg[39:32]),
        .blue  (pix_reg[47:40]),
        .gray  (gray_second)
    );

    always_comb begin
        diff      = (gray_first > gray_second) ? (gray_first - gray_second)
                                               : (gray_second - gray_first);
        alpha     = 8'hFF - diff;
        // round-half-up mean: (a + c + 1) >> 1
        sum_red   = 9'(pix_reg[7:0])   + 9'(pix_reg[31:24]) + 9'd1;
        sum_green = 9'(pix_reg[15:8])  + 9'(pix_reg[39:32]) + 9'd1;
        sum_blue  = 9'(pix_reg[23:16]) + 9'(pix_reg[47:40]) + 9'd1;
    end

    // ---------------------------------------------------------------
    // Position and bounding box; state moves when the pixel leaves the
    // input register, so the result carries the box after this pixel.
    // ---------------------------------------------------------------
    dae_ctrl_t   trk_ctrl;
    dae_status_t trk_status;

    assign trk_ctrl.restart = size_write;
    assign trk_ctrl.advance = a_advance;

    dae_tracker #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (trk_ctrl),
        .diff_max  (diff == 8'hFF),
        .last_col  (last_col),
        .last_line (last_line),
        .status    (trk_status)
    );

    // ---------------------------------------------------------------
    // Result register.
    // ---------------------------------------------------------------
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tlast_reg;
    logic             m_tuser_reg;

    assign m_tvalid_next = b_ready ? a_valid_reg : m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_advance) begin
            m_tdata_reg <= {trk_status.box_bottom, trk_status.box_top,
                            trk_status.box_right, trk_status.box_left,
                            alpha, sum_blue[8:1], sum_green[8:1], sum_red[8:1], diff};
            m_tlast_reg <= trk_status.frame_done;
            m_tuser_reg <= trk_status.crop_apply;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `DAE_ASSERT_NEXT(a_stage_hold, aclk, aresetn, a_valid_reg && !b_ready, a_valid_reg && $stable(pix_reg), "input register lost a stalled pixel")
    `DAE_ASSERT_NEXT(a_out_load, aclk, aresetn, a_advance, m_tvalid_reg, "result register missed a pixel")
    `DAE_ASSERT_NOW(a_crop_at_end, aclk, aresetn, m_tvalid_reg && m_tuser_reg, m_tlast_reg, "crop flagged away from frame end")

endmodule
